[rtl/prlk_pkg.sv]
package prlk_pkg;

	typedef enum logic [1:0] {
		CFG_MIN_FRONT = 2'd0,
		CFG_MIN_REAR  = 2'd1,
		CFG_MAX_LEN   = 2'd2
	} cfg_reg_t;

	localparam logic [15:0] MIN_FRONT_RST = 16'd34368;
	localparam logic [15:0] MIN_REAR_RST  = 16'd34432;
	localparam logic [15:0] MAX_LEN_RST   = 16'd53632;
	localparam logic [15:0] LEG_LEN_RST   = 16'd34432;

	localparam logic [30:0] SIN_C1 = 31'd1686629713;
	localparam logic [30:0] SIN_C3 = 31'd693598668;
	localparam logic [30:0] SIN_C5 = 31'd85569306;
	localparam logic [30:0] SIN_C7 = 31'd5026994;
	localparam logic [30:0] SIN_C9 = 31'd172272;

	localparam logic [14:0] QUARTER = 15'd16384;

	localparam logic signed [31:0] GEO_CY = 32'sd9984;
	localparam logic signed [31:0] GEO_A  = 32'sd9600;

	localparam logic signed [18:0] SPEED_MAX = 19'sd262143;
	localparam logic signed [18:0] SPEED_MIN = -19'sd262144;

	// horner coefficients after the leading one
	function automatic logic [30:0] horner_coef(input logic [1:0] k);
		logic [30:0] c;
		unique case (k)
			2'd0: c = SIN_C7;
			2'd1: c = SIN_C5;
			2'd2: c = SIN_C3;
			default: c = SIN_C1;
		endcase
		return c;
	endfunction

	function automatic logic signed [18:0] anchor_bx(input logic [1:0] leg);
		logic signed [18:0] v;
		unique case (leg)
			2'd0: v = 19'sd16000;
			2'd1: v = 19'sd32000;
			2'd2: v = -19'sd32000;
			default: v = -19'sd16000;
		endcase
		return v;
	endfunction

	function automatic logic signed [18:0] anchor_by(input logic [1:0] leg);
		logic signed [18:0] v;
		unique case (leg)
			2'd1, 2'd2: v = 19'sd7680;
			default: v = 19'sd0;
		endcase
		return v;
	endfunction

endpackage

[rtl/prlk_if.sv]
interface prlk_pose_if;
	logic               valid;
	logic               ready;
	logic signed [16:0] pose_x;
	logic signed [16:0] pose_y;
	logic        [15:0] pose_angle;
	logic signed [16:0] vel_x;
	logic signed [16:0] vel_y;
	logic signed [15:0] vel_angle;
	logic        [2:0]  motion_tag;

	modport source(output valid, pose_x, pose_y, pose_angle, vel_x, vel_y, vel_angle,
		motion_tag, input ready);
	modport sink(input valid, pose_x, pose_y, pose_angle, vel_x, vel_y, vel_angle,
		motion_tag, output ready);
endinterface

interface prlk_leg_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  leg_index;
	logic signed [18:0] leg_speed;
	logic signed [16:0] length_change;
	logic        [2:0]  tag_out;
	logic               last_leg;

	modport source(output valid, leg_index, leg_speed, length_change, tag_out, last_leg,
		input ready);
	modport sink(input valid, leg_index, leg_speed, length_change, tag_out, last_leg,
		output ready);
endinterface

[rtl/prlk_mul.sv]
module prlk_mul (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [29:0] b,
	output logic signed [61:0] prod_q
);
	always_ff @(posedge clk) begin
		prod_q <= 62'(a) * 62'(b);
	end
endmodule

[rtl/prlk_sqrt.sv]
module prlk_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [35:0] radicand,
	output logic        busy,
	output logic [17:0] root
);
	logic [35:0] rem_q;
	logic [35:0] res_q;
	logic [35:0] bit_q;
	logic        busy_q;
	logic [35:0] trial;

	assign trial = res_q + bit_q;
	assign busy  = busy_q;
	assign root  = res_q[17:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rem_q  <= '0;
			res_q  <= '0;
			bit_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			rem_q  <= radicand;
			res_q  <= '0;
			bit_q  <= 36'd1 << 34;
		end else if (busy_q) begin
			if (bit_q != '0) begin
				if (rem_q >= trial) begin
					rem_q <= rem_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else begin
				// round to nearest
				if (rem_q > res_q) begin
					res_q <= res_q + 36'd1;
				end
				busy_q <= 1'b0;
			end
		end
	end
endmodule

[rtl/prlk_div.sv]
module prlk_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [41:0] num,
	input  logic [15:0] den,
	output logic        busy,
	output logic        ovf,
	output logic [18:0] quot
);
	logic [15:0] rem_q;
	logic [18:0] sh_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        ovf_q;
	logic [16:0] trial;
	logic        big;

	assign trial = {rem_q, sh_q[18]};
	assign big   = num[41:19] >= {7'd0, den};
	assign busy  = busy_q;
	assign ovf   = ovf_q;
	assign quot  = sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ovf_q  <= 1'b0;
			rem_q  <= '0;
			sh_q   <= '0;
			cnt_q  <= '0;
		end else if (start) begin
			ovf_q  <= big;
			busy_q <= !big;
			rem_q  <= num[34:19];
			sh_q   <= num[18:0];
			cnt_q  <= 5'd19;
		end else if (busy_q) begin
			if (trial >= {1'b0, den}) begin
				rem_q <= 16'(trial - {1'b0, den});
				sh_q  <= {sh_q[17:0], 1'b1};
			end else begin
				rem_q <= trial[15:0];
				sh_q  <= {sh_q[17:0], 1'b0};
			end
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
			end
		end
	end
endmodule

[rtl/parallel_robot_leg_kinematics.sv]
// a pose that fails the length limits is dropped in the length pass, before any leg
// command of that pose is sent
// one pose at a time: the shared multiplier runs 36 products, and the serial root and
// the serial divider each work on one leg at a time
// asynchronous active-low reset idles the sequencer and sets limits and stored leg lengths to their reset values
module parallel_robot_leg_kinematics (
	input  logic                  clk,
	input  logic                  arst_n,
	prlk_pose_if.sink             pose,
	prlk_leg_if.source            leg,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [15:0]           cfg_data
);
	import prlk_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_Z2, S_Z2W, S_HRN, S_HRNW, S_FIN, S_FINW, S_GEO, S_GEOW, S_VEL, S_VELW,
		S_EXY, S_SQX, S_SQXW, S_SQY, S_SQYW, S_ROOT, S_NX, S_NXW, S_NY, S_NYW, S_DIV, S_PUT
	} state_t;

	state_t state_q;

	logic [15:0] min_front_q, min_rear_q, max_len_q;
	logic [15:0] stored_q [4];

	logic signed [16:0] x_q, y_q, vx_q, vy_q;
	logic        [15:0] ang_q;
	logic signed [15:0] w_q;
	logic        [2:0]  tag_q;

	logic [1:0]  k_q, leg_q;
	logic        pass_q;
	logic [14:0] t_q, qs0_q;
	logic [28:0] z2_q;
	logic [30:0] p_q;
	logic signed [15:0] sin_q, cos_q;
	logic signed [28:0] geo_q [4];
	logic signed [18:0] rv_q [4];
	logic signed [18:0] ex_q [4], ey_q [4];
	logic [17:0] len_q [4];
	logic signed [40:0] acc_q;
	logic        neg_q;

	logic               vld_q;
	logic [1:0]         o_leg_q;
	logic signed [18:0] o_speed_q;
	logic signed [16:0] o_change_q;
	logic [2:0]         o_tag_q;
	logic               o_last_q;

	logic signed [31:0] mul_a;
	logic signed [29:0] mul_b;
	logic signed [61:0] prod;

	logic        sq_start, sq_busy;
	logic [35:0] sq_in;
	logic [17:0] sq_root;
	logic        dv_start, dv_busy, dv_ovf;
	logic [41:0] dv_num;
	logic [18:0] dv_quot;

	logic [46:0] fin_sum;
	logic [16:0] fin_raw;
	logic [14:0] qv;
	logic [30:0] hrn_next;
	logic signed [29:0] kv;
	logic signed [61:0] vr_sum;
	logic signed [29:0] sx, sy;
	logic signed [18:0] ex_new, ey_new;
	logic signed [19:0] vpx, vpy;
	logic signed [40:0] num;
	logic [41:0] mag;
	logic [15:0] lo_lim;
	logic        len_bad;
	logic signed [18:0] speed;
	logic        out_free;

	prlk_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_q(prod));

	prlk_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(sq_in),
		.busy(sq_busy), .root(sq_root));

	prlk_div u_div (.clk(clk), .arst_n(arst_n), .start(dv_start), .num(dv_num),
		.den(len_q[leg_q][15:0]), .busy(dv_busy), .ovf(dv_ovf), .quot(dv_quot));

	assign pose.ready = (state_q == S_IDLE);
	assign leg.valid = vld_q;
	assign leg.leg_index = o_leg_q;
	assign leg.leg_speed = o_speed_q;
	assign leg.length_change = o_change_q;
	assign leg.tag_out = o_tag_q;
	assign leg.last_leg = o_last_q;
	assign out_free = !vld_q || leg.ready;

	always_comb begin
		fin_sum  = prod[46:0] + (47'd1 << 29);
		fin_raw  = fin_sum[46:30];
		qv       = (fin_raw > 17'(QUARTER)) ? QUARTER : fin_raw[14:0];
		hrn_next = horner_coef(k_q) - prod[58:28];
		unique case (k_q)
			2'd0: kv = 30'(geo_q[2]) - 30'(geo_q[3]);
			2'd1: kv = 30'(geo_q[2]) + 30'(geo_q[3]);
			2'd2: kv = 30'(geo_q[1]) - 30'(geo_q[0]);
			default: kv = -30'(geo_q[1]) - 30'(geo_q[0]);
		endcase
		vr_sum = (prod + (62'sd1 <<< 25)) >>> 26;
		if (!leg_q[1]) begin
			sx = 30'(geo_q[0]) + 30'(geo_q[1]);
			sy = 30'(geo_q[2]) + 30'(geo_q[3]);
		end else begin
			sx = 30'(geo_q[0]) - 30'(geo_q[1]);
			sy = 30'(geo_q[2]) - 30'(geo_q[3]);
		end
		sx = (sx + 30'sd8192) >>> 14;
		sy = (sy + 30'sd8192) >>> 14;
		ex_new = 19'(x_q) - anchor_bx(leg_q) + 19'(sx);
		ey_new = 19'(y_q) - anchor_by(leg_q) + 19'(sy);
		vpx = 20'(vx_q) + 20'(rv_q[{1'b0, leg_q[1]}]);
		vpy = 20'(vy_q) + 20'(rv_q[{1'b1, leg_q[1]}]);
		num = acc_q + prod[40:0];
		mag = num[40] ? 42'(-num) : 42'(num);
		dv_num = mag + 42'(len_q[leg_q][15:1]);
		sq_in = 36'(acc_q) + prod[35:0];
		lo_lim = leg_q[1] ? min_rear_q : min_front_q;
		len_bad = (sq_root < 18'(lo_lim)) || (sq_root > 18'(max_len_q));
		sq_start = (state_q == S_SQYW);
		dv_start = (state_q == S_NYW) && (len_q[leg_q] != '0);
		if (len_q[leg_q] == '0) begin
			speed = '0;
		end else if (!neg_q) begin
			speed = (dv_ovf || dv_quot[18]) ? SPEED_MAX : $signed(dv_quot);
		end else begin
			speed = (dv_ovf || dv_quot > 19'd262144) ? SPEED_MIN : -$signed(dv_quot);
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_Z2: begin
				mul_a = 32'(t_q);
				mul_b = 30'(t_q);
			end
			S_HRN: begin
				mul_a = 32'(p_q);
				mul_b = 30'(z2_q);
			end
			S_FIN: begin
				mul_a = 32'(p_q);
				mul_b = 30'(t_q);
			end
			S_GEO: begin
				mul_a = k_q[0] ? GEO_A : GEO_CY;
				mul_b = (k_q == 2'd0 || k_q == 2'd3) ? 30'(sin_q) : 30'(cos_q);
			end
			S_VEL: begin
				mul_a = 32'(kv);
				mul_b = 30'(w_q);
			end
			S_SQX: begin
				mul_a = 32'(ex_q[leg_q]);
				mul_b = 30'(ex_q[leg_q]);
			end
			S_SQY: begin
				mul_a = 32'(ey_q[leg_q]);
				mul_b = 30'(ey_q[leg_q]);
			end
			S_NX: begin
				mul_a = 32'(ex_q[leg_q]);
				mul_b = 30'(vpx);
			end
			S_NY: begin
				mul_a = 32'(ey_q[leg_q]);
				mul_b = 30'(vpy);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			min_front_q <= MIN_FRONT_RST;
			min_rear_q  <= MIN_REAR_RST;
			max_len_q   <= MAX_LEN_RST;
			for (int i = 0; i < 4; i++) begin
				stored_q[i] <= LEG_LEN_RST;
			end
			vld_q  <= 1'b0;
			k_q    <= '0;
			leg_q  <= '0;
			pass_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MIN_FRONT: min_front_q <= cfg_data;
					CFG_MIN_REAR:  min_rear_q  <= cfg_data;
					CFG_MAX_LEN:   max_len_q   <= cfg_data;
					default: ;
				endcase
			end
			if (vld_q && leg.ready && (state_q != S_PUT)) begin
				vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pose.valid) begin
						x_q    <= pose.pose_x;
						y_q    <= pose.pose_y;
						ang_q  <= pose.pose_angle;
						vx_q   <= pose.vel_x;
						vy_q   <= pose.vel_y;
						w_q    <= pose.vel_angle;
						tag_q  <= pose.motion_tag;
						t_q    <= {1'b0, pose.pose_angle[13:0]};
						pass_q <= 1'b0;
						state_q <= S_Z2;
					end
				end
				S_Z2: state_q <= S_Z2W;
				S_Z2W: begin
					z2_q    <= prod[28:0];
					p_q     <= SIN_C9;
					k_q     <= '0;
					state_q <= S_HRN;
				end
				S_HRN: state_q <= S_HRNW;
				S_HRNW: begin
					p_q <= hrn_next;
					k_q <= k_q + 2'd1;
					state_q <= (k_q == 2'd3) ? S_FIN : S_HRN;
				end
				S_FIN: state_q <= S_FINW;
				S_FINW: begin
					if (!pass_q) begin
						qs0_q   <= qv;
						t_q     <= QUARTER - {1'b0, ang_q[13:0]};
						pass_q  <= 1'b1;
						state_q <= S_Z2;
					end else begin
						unique case (ang_q[15:14])
							2'd0: begin
								sin_q <= 16'(qs0_q);
								cos_q <= 16'(qv);
							end
							2'd1: begin
								sin_q <= 16'(qv);
								cos_q <= -16'(qs0_q);
							end
							2'd2: begin
								sin_q <= -16'(qs0_q);
								cos_q <= -16'(qv);
							end
							default: begin
								sin_q <= -16'(qv);
								cos_q <= 16'(qs0_q);
							end
						endcase
						k_q     <= '0;
						state_q <= S_GEO;
					end
				end
				S_GEO: state_q <= S_GEOW;
				S_GEOW: begin
					geo_q[k_q] <= prod[28:0];
					k_q <= k_q + 2'd1;
					state_q <= (k_q == 2'd3) ? S_VEL : S_GEO;
				end
				S_VEL: state_q <= S_VELW;
				S_VELW: begin
					rv_q[k_q] <= vr_sum[18:0];
					k_q <= k_q + 2'd1;
					leg_q <= '0;
					state_q <= (k_q == 2'd3) ? S_EXY : S_VEL;
				end
				S_EXY: begin
					ex_q[leg_q] <= ex_new;
					ey_q[leg_q] <= ey_new;
					state_q <= S_SQX;
				end
				S_SQX: state_q <= S_SQXW;
				S_SQXW: begin
					acc_q   <= prod[40:0];
					state_q <= S_SQY;
				end
				S_SQY: state_q <= S_SQYW;
				S_SQYW: state_q <= S_ROOT;
				S_ROOT: begin
					if (!sq_busy) begin
						len_q[leg_q] <= sq_root;
						leg_q <= leg_q + 2'd1;
						if (len_bad) begin
							state_q <= S_IDLE;
						end else if (leg_q == 2'd3) begin
							state_q <= S_NX;
						end else begin
							state_q <= S_EXY;
						end
					end
				end
				S_NX: state_q <= S_NXW;
				S_NXW: begin
					acc_q   <= prod[40:0];
					state_q <= S_NY;
				end
				S_NY: state_q <= S_NYW;
				S_NYW: begin
					neg_q   <= num[40];
					state_q <= (len_q[leg_q] == '0) ? S_PUT : S_DIV;
				end
				S_DIV: begin
					if (!dv_busy) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (out_free) begin
						vld_q      <= 1'b1;
						o_leg_q    <= leg_q;
						o_speed_q  <= speed;
						o_change_q <= 17'(len_q[leg_q]) - 17'(stored_q[leg_q]);
						o_tag_q    <= tag_q;
						o_last_q   <= (leg_q == 2'd3);
						stored_q[leg_q] <= len_q[leg_q][15:0];
						leg_q <= leg_q + 2'd1;
						state_q <= (leg_q == 2'd3) ? S_IDLE : S_NX;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[rtl/prlk_chk.sv]
module prlk_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         out_leg_index,
	input logic signed [18:0] out_speed,
	input logic signed [16:0] out_change,
	input logic               out_last
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_leg_index)
			&& $stable(out_speed) && $stable(out_change))
		else $error("leg command changed while stalled");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_last == (out_leg_index == 2'd3))
		else $error("last flag does not match leg index");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("new pose taken in the middle of a leg run");

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("pose taken on back to back cycles");
endmodule

bind parallel_robot_leg_kinematics prlk_chk u_prlk_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(pose.valid),
	.in_ready(pose.ready),
	.out_valid(leg.valid),
	.out_ready(leg.ready),
	.out_leg_index(leg.leg_index),
	.out_speed(leg.leg_speed),
	.out_change(leg.length_change),
	.out_last(leg.last_leg)
);

[tb/sv/prlk_leg_checker.sv]
module prlk_leg_checker (
	input  logic        clk,
	input  logic        arst_n,
	prlk_pose_if        pose,
	prlk_leg_if         leg,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output int          poses_seen,
	output int          poses_rejected,
	output int          commands_seen
);
	import prlk_pkg::*;

	typedef struct packed {
		logic        [1:0]  leg_index;
		logic signed [18:0] leg_speed;
		logic signed [16:0] length_change;
		logic        [2:0]  tag_out;
		logic               last_leg;
	} leg_cmd_t;

	localparam longint ANCHOR_BX [4] = '{16000, 32000, -32000, -16000};
	localparam longint ANCHOR_BY [4] = '{0, 7680, 7680, 0};

	logic [15:0] lim_front, lim_rear, lim_max;
	logic [15:0] leg_len [4];
	leg_cmd_t    leg_cmd_q [$];

	assign pending = leg_cmd_q.size();

	function automatic longint sine_q14(input logic [13:0] r_lo, input logic top);
		logic [63:0] r, z2, p, s;
		r  = top ? 64'd16384 : 64'(r_lo);
		z2 = r * r;
		p  = 64'(SIN_C9);
		p  = 64'(SIN_C7) - ((p * z2) >> 28);
		p  = 64'(SIN_C5) - ((p * z2) >> 28);
		p  = 64'(SIN_C3) - ((p * z2) >> 28);
		p  = 64'(SIN_C1) - ((p * z2) >> 28);
		s  = (r * p + 64'd536870912) >> 30;
		if (s > 64'd16384) begin
			s = 64'd16384;
		end
		return longint'(s);
	endfunction

	// sine of quarter-wave position r, or of (16384 - r)
	function automatic longint quarter_sine(input logic [13:0] r, input logic mirror);
		logic [14:0] m;
		m = 15'd16384 - 15'(r);
		return mirror ? sine_q14(m[13:0], m[14]) : sine_q14(r, 1'b0);
	endfunction

	function automatic longint round_shift(input longint v, input int n);
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic longint root_round(input logic [63:0] v);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) begin
			b = b >> 2;
		end
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		if (v > res) begin
			res = res + 1;
		end
		return longint'(res);
	endfunction

	task automatic solve_legs();
		longint x, y, vx, vy, w, s, c, ga, lo, vpx, vpy, num, m, sp, d;
		longint ex [4];
		longint ey [4];
		longint len [4];
		logic [1:0]  quad;
		logic [13:0] r;
		leg_cmd_t    cmd;
		x = longint'(pose.pose_x);
		y = longint'(pose.pose_y);
		vx = longint'(pose.vel_x);
		vy = longint'(pose.vel_y);
		w = longint'(pose.vel_angle);
		quad = pose.pose_angle[15:14];
		r = pose.pose_angle[13:0];
		case (quad)
			2'd0: begin
				s = quarter_sine(r, 0);
				c = quarter_sine(r, 1);
			end
			2'd1: begin
				s = quarter_sine(r, 1);
				c = -quarter_sine(r, 0);
			end
			2'd2: begin
				s = -quarter_sine(r, 0);
				c = -quarter_sine(r, 1);
			end
			default: begin
				s = -quarter_sine(r, 1);
				c = quarter_sine(r, 0);
			end
		endcase
		for (int i = 0; i < 4; i++) begin
			ga = (i < 2) ? longint'(GEO_A) : -longint'(GEO_A);
			lo = (i < 2) ? longint'(lim_front) : longint'(lim_rear);
			ex[i] = x - ANCHOR_BX[i] + round_shift(longint'(GEO_CY) * s + ga * c, 14);
			ey[i] = y - ANCHOR_BY[i] + round_shift(longint'(GEO_CY) * c + ga * s, 14);
			len[i] = root_round(64'(ex[i] * ex[i]) + 64'(ey[i] * ey[i]));
			if (len[i] < lo || len[i] > longint'(lim_max)) begin
				poses_rejected++;
				return;
			end
		end
		for (int i = 0; i < 4; i++) begin
			ga = (i < 2) ? longint'(GEO_A) : -longint'(GEO_A);
			vpx = vx + round_shift((longint'(GEO_CY) * c - ga * s) * w, 26);
			vpy = vy + round_shift((ga * c - longint'(GEO_CY) * s) * w, 26);
			num = ex[i] * vpx + ey[i] * vpy;
			d = len[i];
			sp = 0;
			if (d != 0) begin
				m = (num < 0) ? -num : num;
				sp = (m + d / 2) / d;
				if (num < 0) begin
					sp = -sp;
				end
			end
			if (sp > longint'(SPEED_MAX)) begin
				sp = longint'(SPEED_MAX);
			end
			if (sp < longint'(SPEED_MIN)) begin
				sp = longint'(SPEED_MIN);
			end
			cmd.leg_index = 2'(i);
			cmd.leg_speed = 19'(sp);
			cmd.length_change = 17'(d - longint'(leg_len[i]));
			cmd.tag_out = pose.motion_tag;
			cmd.last_leg = (i == 3);
			leg_cmd_q.push_back(cmd);
		end
		for (int i = 0; i < 4; i++) begin
			leg_len[i] = 16'(len[i]);
		end
	endtask

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		leg_cmd_t want;
		if (!arst_n) begin
			lim_front <= MIN_FRONT_RST;
			lim_rear <= MIN_REAR_RST;
			lim_max <= MAX_LEN_RST;
			for (int i = 0; i < 4; i++) begin
				leg_len[i] <= LEG_LEN_RST;
			end
		end else begin
			if (leg.valid && leg.ready) begin
				commands_seen++;
				if (leg_cmd_q.size() == 0) begin
					report("unexpected leg command, leg", leg.leg_index, -1);
				end else begin
					want = leg_cmd_q.pop_front();
					if (leg.leg_index !== want.leg_index)
						report("leg_index", leg.leg_index, want.leg_index);
					if (leg.leg_speed !== want.leg_speed)
						report("leg_speed", leg.leg_speed, want.leg_speed);
					if (leg.length_change !== want.length_change)
						report("length_change", leg.length_change, want.length_change);
					if (leg.tag_out !== want.tag_out)
						report("tag_out", leg.tag_out, want.tag_out);
					if (leg.last_leg !== want.last_leg)
						report("last_leg", leg.last_leg, want.last_leg);
				end
			end
			if (pose.valid && pose.ready) begin
				poses_seen++;
				solve_legs();
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_MIN_FRONT: lim_front <= cfg_data;
					CFG_MIN_REAR: lim_rear <= cfg_data;
					CFG_MAX_LEN: lim_max <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	initial begin
		fail_count = 0;
		poses_seen = 0;
		poses_rejected = 0;
		commands_seen = 0;
	end
endmodule

[tb/sv/tb_top.sv]
module tb_top;
	import prlk_pkg::*;

	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int         DRAIN_WAIT = 300;
	localparam int         STALL_LIMIT = 5000;

	typedef struct {
		logic signed [16:0] x;
		logic signed [16:0] y;
		logic        [15:0] angle;
		logic signed [16:0] vx;
		logic signed [16:0] vy;
		logic signed [15:0] w;
		logic        [2:0]  tag;
	} pose_req_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	int          tx_idle_pct;
	int          rx_idle_pct;
	int          stall_cycles;
	int          fail_count, pending, poses_seen, poses_rejected, commands_seen;

	prlk_pose_if pose ();
	prlk_leg_if  leg ();

	parallel_robot_leg_kinematics dut (
		.clk(clk),
		.arst_n(arst_n),
		.pose(pose),
		.leg(leg),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	prlk_leg_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.pose(pose),
		.leg(leg),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending),
		.poses_seen(poses_seen),
		.poses_rejected(poses_rejected),
		.commands_seen(commands_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		leg.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if ((pose.valid && pose.ready) || (leg.valid && leg.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic pose_req_t make_pose(input logic signed [16:0] x,
			input logic signed [16:0] y, input logic [15:0] angle,
			input logic signed [16:0] vx, input logic signed [16:0] vy,
			input logic signed [15:0] w, input logic [2:0] tag);
		pose_req_t p;
		p.x = x;
		p.y = y;
		p.angle = angle;
		p.vx = vx;
		p.vy = vy;
		p.w = w;
		p.tag = tag;
		return p;
	endfunction

	// mostly poses near the workspace, some pure noise
	function automatic pose_req_t random_pose();
		pose_req_t p;
		p.vx = 17'($urandom);
		p.vy = 17'($urandom);
		p.w = 16'($urandom);
		p.tag = 3'($urandom);
		if ($urandom_range(99) < 25) begin
			p.x = 17'($urandom);
			p.y = 17'($urandom);
			p.angle = 16'($urandom);
		end else begin
			p.x = 17'($urandom_range(16000) - 8000);
			p.y = 17'($urandom_range(44000, 26000));
			if ($urandom_range(1)) begin
				p.y = -p.y;
			end
			case ($urandom_range(2))
				0: p.angle = 16'($urandom_range(2000));
				1: p.angle = 16'(65535 - $urandom_range(2000));
				default: p.angle = 16'($urandom);
			endcase
		end
		return p;
	endfunction

	task automatic send_pose(input pose_req_t p);
		while ($urandom_range(99) < tx_idle_pct) begin
			pose.valid <= 1'b0;
			@(posedge clk);
		end
		pose.valid <= 1'b1;
		pose.pose_x <= p.x;
		pose.pose_y <= p.y;
		pose.pose_angle <= p.angle;
		pose.vel_x <= p.vx;
		pose.vel_y <= p.vy;
		pose.vel_angle <= p.w;
		pose.motion_tag <= p.tag;
		do @(posedge clk); while (!pose.ready);
	endtask

	// hold requests until every leg command is out, then let a rejected pose finish
	task automatic drain();
		pose.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_limits(input logic [15:0] front, input logic [15:0] rear,
			input logic [15:0] upper);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MIN_FRONT;
		cfg_data <= front;
		@(posedge clk);
		cfg_index <= CFG_MIN_REAR;
		cfg_data <= rear;
		@(posedge clk);
		cfg_index <= CFG_MAX_LEN;
		cfg_data <= upper;
		@(posedge clk);
		cfg_index <= CFG_UNUSED;
		cfg_data <= 16'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MIN_FRONT;
		cfg_data = '0;
		pose.valid = 1'b0;
		pose.pose_x = '0;
		pose.pose_y = '0;
		pose.pose_angle = '0;
		pose.vel_x = '0;
		pose.vel_y = '0;
		pose.vel_angle = '0;
		pose.motion_tag = '0;
		leg.ready = 1'b0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		stall_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limits: workspace poses, quadrants, tags, speed extremes
		send_pose(make_pose(0, 30000, 0, 0, 0, 0, 0));
		send_pose(make_pose(2000, 32000, 500, 65535, -65536, 32767, 7));
		send_pose(make_pose(-3000, -40000, 65000, -65536, 65535, -32768, 5));
		send_pose(make_pose(0, 30000, 16384, 100, 200, 10, 1));
		send_pose(make_pose(0, 30000, 32768, 100, 200, 10, 2));
		send_pose(make_pose(0, -30000, 49152, 100, 200, 10, 3));
		send_pose(make_pose(65535, 65535, 65535, 65535, 65535, 32767, 7));
		send_pose(make_pose(-65536, -65536, 0, -65536, -65536, -32768, 0));
		send_pose(make_pose(1000, 28000, 1200, 65535, 65535, 32767, 4));
		send_pose(make_pose(-1000, 42000, 64000, -65536, -65536, -32768, 6));
		drain();

		// widest window: zero length on leg 0 and big poses
		set_limits(16'd0, 16'd0, 16'd65535);
		send_pose(make_pose(6400, -9984, 0, 1234, -4321, 99, 3));
		send_pose(make_pose(0, 0, 0, 65535, 65535, 32767, 1));
		send_pose(make_pose(40000, -40000, 20000, -65536, 65535, -32768, 2));
		drain();
		set_limits(16'd65535, 16'd65535, 16'd0);
		send_pose(make_pose(0, 30000, 0, 0, 0, 0, 5));
		send_pose(make_pose(6400, -9984, 0, 0, 0, 0, 6));
		drain();

		set_limits(MIN_FRONT_RST, MIN_REAR_RST, MAX_LEN_RST);
		tx_idle_pct = 23;
		rx_idle_pct = 76;
		for (int i = 0; i < 120; i++) begin
			send_pose(random_pose());
		end
		drain();

		set_limits(16'd30000, 16'd32000, 16'd58000);
		tx_idle_pct = 76;
		rx_idle_pct = 23;
		for (int i = 0; i < 120; i++) begin
			send_pose(random_pose());
		end
		drain();

		set_limits(16'($urandom_range(34400, 33000)), 16'($urandom_range(34400, 33000)),
			16'($urandom_range(56000, 52000)));
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		for (int i = 0; i < 120; i++) begin
			send_pose(random_pose());
		end
		drain();

		$display("poses sent %0d, rejected outside workspace %0d, leg commands checked %0d",
			poses_seen, poses_rejected, commands_seen);
		$display("limit sets: reset, open, closed, wide, random; mismatches %0d", fail_count);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

[filelist.f]
rtl/prlk_pkg.sv
rtl/prlk_if.sv
rtl/prlk_mul.sv
rtl/prlk_sqrt.sv
rtl/prlk_div.sv
rtl/parallel_robot_leg_kinematics.sv
rtl/prlk_chk.sv
tb/sv/prlk_leg_checker.sv
tb/sv/tb_top.sv
